// ===== src/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  // Width of the noise registers and of the configuration data.
  localparam int unsigned NOISE_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEN,
    ST_DIV,
    ST_MULINIT,
    ST_MUL,
    ST_CORR,
    ST_EST,
    ST_OUT
  } ctrl_state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEN,
    OP_DIV,
    OP_MULINIT,
    OP_MUL,
    OP_CORR,
    OP_EST,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } skf_cmd_t;

  typedef struct packed {
    logic out_busy;
  } skf_status_t;

endpackage

// ===== src/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: controller, datapath and ports.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_axis_tvalid/tready      measurement
//  m_axis    out        m_axis_tvalid/tready      estimate
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// An accepted item passes through these steps in order: load, denominator, FRAC_BITS+1
// restoring division steps for the gain, multiplier set-up, FRAC_BITS+1 shift-add steps for
// the two products, covariance and correction update, estimate update and output write.
// One item is worked on at a time; the next is accepted once the result is registered.
// If the output register is still full, the finished item waits until it drains.
// Reset clears the estimate and covariance and loads Q=1, R=30; config is always ready.
module scalar_kalman_filter #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Bits from the lowest up: measurement, zero fill.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Bits from the lowest up: estimate, zero fill.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [skf_pkg::NOISE_W-1:0]       cfg_data_i
);

  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  skf_pkg::skf_cmd_t    cmd;
  skf_pkg::skf_status_t status;
  logic [SAMPLE_BITS-1:0] out_data;

  assign cfg_ready_o = 1'b1;

  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  skf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .meas_i      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = DATA_W'(out_data);

  // An accepted item starts the sequence with a load of the datapath.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (cmd.op == skf_pkg::OP_LOAD))
    else $error("accepted item did not load the datapath");

  // Only one item is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in flight");

  // A result is only written into an empty output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == skf_pkg::OP_OUT) |-> !m_axis_tvalid)
    else $error("output register overwritten before it was taken");

  // A written result shows up on the output in the next cycle.
  a_out_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == skf_pkg::OP_OUT) |=> m_axis_tvalid)
    else $error("written result not presented");

endmodule

// ===== src/skf_ctrl.sv =====
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  skf_pkg::skf_status_t status_i,
  output skf_pkg::skf_cmd_t    cmd_o
);

  localparam int unsigned CW = $clog2(FRAC_BITS + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(FRAC_BITS);

  skf_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      skf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = skf_pkg::ST_DEN;
        end
      end
      skf_pkg::ST_DEN: begin
        state_d = skf_pkg::ST_DIV;
        cnt_d   = '0;
      end
      skf_pkg::ST_DIV: begin
        if (cnt_q == LAST_STEP) begin
          state_d = skf_pkg::ST_MULINIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      skf_pkg::ST_MULINIT: begin
        state_d = skf_pkg::ST_MUL;
      end
      skf_pkg::ST_MUL: begin
        if (cnt_q == LAST_STEP) begin
          state_d = skf_pkg::ST_CORR;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      skf_pkg::ST_CORR: begin
        state_d = skf_pkg::ST_EST;
      end
      skf_pkg::ST_EST: begin
        state_d = skf_pkg::ST_OUT;
      end
      skf_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          state_d = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skf_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = skf_pkg::OP_NONE;
    unique case (state_q)
      skf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = skf_pkg::OP_LOAD;
        end
      end
      skf_pkg::ST_DEN:     cmd_o.op = skf_pkg::OP_DEN;
      skf_pkg::ST_DIV:     cmd_o.op = skf_pkg::OP_DIV;
      skf_pkg::ST_MULINIT: cmd_o.op = skf_pkg::OP_MULINIT;
      skf_pkg::ST_MUL:     cmd_o.op = skf_pkg::OP_MUL;
      skf_pkg::ST_CORR:    cmd_o.op = skf_pkg::OP_CORR;
      skf_pkg::ST_EST:     cmd_o.op = skf_pkg::OP_EST;
      skf_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = skf_pkg::OP_OUT;
        end
      end
      default: begin
        cmd_o.op = skf_pkg::OP_NONE;
      end
    endcase
  end

endmodule

// ===== src/skf_dp.sv =====
// Datapath of the scalar Kalman filter: state, divider, shift-add multipliers, output register.
module skf_dp #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skf_pkg::skf_cmd_t                   cmd_i,
  output skf_pkg::skf_status_t                status_o,
  input  logic [SAMPLE_BITS-1:0]              meas_i,
  input  logic                                cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [skf_pkg::NOISE_W-1:0]         cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [SAMPLE_BITS-1:0]              out_data_o
);

  localparam int unsigned SW  = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned NW  = skf_pkg::NOISE_W + FRAC_BITS;
  localparam int unsigned DW  = ((SW > NW) ? SW : NW) + 1;
  localparam int unsigned MW  = SW + 1;
  localparam int unsigned GW  = FRAC_BITS + 1;
  localparam int unsigned A1W = GW + MW;
  localparam int unsigned A2W = GW + SW;

  localparam logic [DW-1:0]  PRIOR_MAX = DW'({SW{1'b1}});
  localparam logic [GW-1:0]  GAIN_ONE  = GW'(1) << FRAC_BITS;
  localparam logic [A1W-1:0] HALF1     = A1W'(1) << (FRAC_BITS - 1);
  localparam logic [A2W-1:0] HALF2     = A2W'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0]  HALF_EST  = MW'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic [skf_pkg::NOISE_W-1:0] q_noise_q, r_noise_q;
  logic [SW-1:0]  est_q, cov_q;
  logic [SW-1:0]  prior_q;
  logic [MW-1:0]  mag_q;
  logic           neg_q;
  logic [DW-1:0]  den_q;
  logic [DW:0]    rem_q;
  logic [GW-1:0]  quot_q;
  logic [GW-1:0]  gsh_q, osh_q;
  logic [A1W-1:0] acc1_q;
  logic [A2W-1:0] acc2_q;
  logic [MW-1:0]  corr_q;
  logic           out_valid_q;
  logic [SAMPLE_BITS-1:0] out_data_q;

  logic [DW-1:0]  prior_sum;
  logic [SW-1:0]  prior_sat;
  logic [MW-1:0]  meas_fix, innov, mag;
  logic [DW+1:0]  diff;
  logic           div_ge;
  logic [DW:0]    rem_nx;
  logic [GW-1:0]  gain;
  logic [A1W-1:0] acc1_d, acc1_rnd;
  logic [A2W-1:0] acc2_d, acc2_rnd;
  logic [SW+1:0]  est_wide, corr_wide, est_new;
  logic [MW-1:0]  est_rnd;
  logic [SAMPLE_BITS:0] out_rnd;
  logic [SAMPLE_BITS-1:0] out_sat;

  // Prior covariance saturates at the full state range.
  always_comb begin
    prior_sum = DW'(cov_q) + (DW'(q_noise_q) << FRAC_BITS);
    prior_sat = (prior_sum > PRIOR_MAX) ? {SW{1'b1}} : prior_sum[SW-1:0];
    meas_fix  = {meas_i[SAMPLE_BITS-1], meas_i, {FRAC_BITS{1'b0}}};
    innov     = meas_fix - {est_q[SW-1], est_q};
    mag       = innov[SW] ? (~innov + 1'b1) : innov;
  end

  // One restoring division step: the first step settles the integer bit of the gain.
  always_comb begin
    diff   = {1'b0, rem_q} - {2'b00, den_q};
    div_ge = !diff[DW+1];
    rem_nx = div_ge ? diff[DW:0] : rem_q;
  end

  assign gain = (den_q == '0) ? '0 : quot_q;

  // MSB-first shift-add multipliers for gain*|innovation| and (1-gain)*prior.
  always_comb begin
    acc1_d   = {acc1_q[A1W-2:0], 1'b0} + (gsh_q[GW-1] ? A1W'(mag_q) : '0);
    acc2_d   = {acc2_q[A2W-2:0], 1'b0} + (osh_q[GW-1] ? A2W'(prior_q) : '0);
    acc1_rnd = acc1_q + HALF1;
    acc2_rnd = acc2_q + HALF2;
  end

  always_comb begin
    est_wide  = {est_q[SW-1], est_q[SW-1], est_q};
    corr_wide = (SW+2)'(corr_q);
    est_new   = neg_q ? (est_wide - corr_wide) : (est_wide + corr_wide);
    // Floor of (estimate + one half), then clip at the largest sample.
    est_rnd   = {est_q[SW-1], est_q} + HALF_EST;
    out_rnd   = est_rnd[SW:FRAC_BITS];
    out_sat   = (!out_rnd[SAMPLE_BITS] && out_rnd[SAMPLE_BITS-1]) ? OUT_MAX
                                                                  : out_rnd[SAMPLE_BITS-1:0];
  end

  // Filter state and configuration; a write to either noise register restarts the filter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= skf_pkg::NOISE_W'(1);
      r_noise_q <= skf_pkg::NOISE_W'(30);
      est_q     <= '0;
      cov_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        skf_pkg::REG_PROCESS_NOISE: begin
          q_noise_q <= cfg_data_i;
          est_q     <= '0;
          cov_q     <= '0;
        end
        skf_pkg::REG_MEASUREMENT_NOISE: begin
          r_noise_q <= cfg_data_i;
          est_q     <= '0;
          cov_q     <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd_i.op == skf_pkg::OP_CORR) begin
        cov_q <= acc2_rnd[FRAC_BITS +: SW];
      end
      if (cmd_i.op == skf_pkg::OP_EST) begin
        est_q <= est_new[SW-1:0];
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      skf_pkg::OP_LOAD: begin
        prior_q <= prior_sat;
        mag_q   <= mag;
        neg_q   <= innov[SW];
      end
      skf_pkg::OP_DEN: begin
        den_q  <= DW'(prior_q) + (DW'(r_noise_q) << FRAC_BITS);
        rem_q  <= (DW+1)'(prior_q);
        quot_q <= '0;
      end
      skf_pkg::OP_DIV: begin
        rem_q  <= {rem_nx[DW-1:0], 1'b0};
        quot_q <= {quot_q[GW-2:0], div_ge};
      end
      skf_pkg::OP_MULINIT: begin
        gsh_q  <= gain;
        osh_q  <= GAIN_ONE - gain;
        acc1_q <= '0;
        acc2_q <= '0;
      end
      skf_pkg::OP_MUL: begin
        gsh_q  <= {gsh_q[GW-2:0], 1'b0};
        osh_q  <= {osh_q[GW-2:0], 1'b0};
        acc1_q <= acc1_d;
        acc2_q <= acc2_d;
      end
      skf_pkg::OP_CORR: begin
        corr_q <= acc1_rnd[FRAC_BITS +: MW];
      end
      skf_pkg::OP_OUT: begin
        out_data_q <= out_sat;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one item until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == skf_pkg::OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

// ===== tb/skf_checker.sv =====
// Checker for the scalar Kalman filter: fixed-point filter model and result comparison.
module skf_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // Bits from the lowest up: measurement.
  input  logic [15:0]                   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Bits from the lowest up: estimate.
  input  logic [15:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [skf_pkg::NOISE_W-1:0]   cfg_data_i,
  input  logic                          run_over_i,
  output int                            outstanding_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC_BITS  = 16;
  localparam longint      ONE_FIX    = 64'd1 << FRAC_BITS;
  localparam longint      HALF_FIX   = ONE_FIX / 2;
  localparam longint      SAMPLE_MAX = 32767;
  localparam logic [63:0] STATE_MAX  = 64'hFFFF_FFFF;

  // Filter state: estimate in signed Q16.16, covariance in unsigned Q16.16.
  logic [31:0]                 est_fix;
  logic [31:0]                 cov_fix;
  logic [skf_pkg::NOISE_W-1:0] q_noise;
  logic [skf_pkg::NOISE_W-1:0] r_noise;

  logic [15:0] estimate_q[$];
  int          pending;
  int          mismatches = 0;
  int          result_idx;
  bit          end_checked;
  logic [15:0] want;

  assign outstanding_o = pending;
  assign fail_count_o  = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // One filter update; returns the rounded, saturated estimate.
  function automatic logic [15:0] filter_update(input logic [15:0] meas_bits);
    longint      meas;
    longint      est;
    longint      innov;
    longint      rounded;
    logic [63:0] prior;
    logic [63:0] den;
    logic [63:0] gain;
    logic [63:0] rem;
    logic [63:0] mag;
    logic [63:0] corr;
    meas  = longint'($signed(meas_bits));
    est   = longint'($signed(est_fix));
    prior = {32'd0, cov_fix} + ({48'd0, q_noise} << FRAC_BITS);
    if (prior > STATE_MAX) prior = STATE_MAX;
    den  = prior + ({48'd0, r_noise} << FRAC_BITS);
    gain = 64'd0;
    // Restoring division; a zero denominator leaves the gain at zero.
    if (den != 64'd0) begin
      rem = prior;
      if (rem >= den) begin
        gain = 64'd1;
        rem  = rem - den;
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem  = rem << 1;
        gain = gain << 1;
        if (rem >= den) begin
          rem  = rem - den;
          gain = gain | 64'd1;
        end
      end
    end
    innov = meas * ONE_FIX - est;
    mag   = (innov < 0) ? 64'(-innov) : 64'(innov);
    // The correction is rounded on its magnitude, so ties go away from zero.
    corr  = (gain * mag + 64'(HALF_FIX)) >> FRAC_BITS;
    est   = (innov < 0) ? est - longint'(corr) : est + longint'(corr);
    cov_fix = 32'((prior * (64'(ONE_FIX) - gain) + 64'(HALF_FIX)) >> FRAC_BITS);
    est_fix = est[31:0];
    rounded = (est + HALF_FIX) >>> FRAC_BITS;
    if (rounded > SAMPLE_MAX) rounded = SAMPLE_MAX;
    return rounded[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_fix    = '0;
      cov_fix    = '0;
      q_noise    = 16'd1;
      r_noise    = 16'd30;
      pending    = 0;
      result_idx = 0;
      estimate_q.delete();
    end else begin
      // Results are taken before new items: no item finishes at its own edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (estimate_q.size() == 0) begin
          report_mismatch($sformatf("estimate %0d arrived with none expected",
                                    $signed(m_axis_tdata)));
        end else begin
          want = estimate_q.pop_front();
          pending--;
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("result %0d: estimate %0d, expected %0d",
                                      result_idx, $signed(m_axis_tdata), $signed(want)));
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        estimate_q.push_back(filter_update(s_axis_tdata));
        pending++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          skf_pkg::REG_PROCESS_NOISE: begin
            q_noise = cfg_data_i;
            est_fix = '0;
            cov_fix = '0;
          end
          skf_pkg::REG_MEASUREMENT_NOISE: begin
            r_noise = cfg_data_i;
            est_fix = '0;
            cov_fix = '0;
          end
          default: ;
        endcase
      end
      if (run_over_i && !end_checked) begin
        end_checked = 1'b1;
        if (estimate_q.size() != 0)
          report_mismatch($sformatf("%0d estimates never arrived", estimate_q.size()));
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the scalar Kalman filter testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the two registers; writes there must be ignored.
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_LIMIT  = 20000;

  typedef enum int {SIG_NOISE, SIG_LEVEL, SIG_SWING, SIG_RAMP} signal_style_e;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [skf_pkg::NOISE_W-1:0]   cfg_data_i    = '0;
  logic                          run_over      = 1'b0;
  bit                            calm          = 1'b0;
  int                            sink_hold     = 0;
  int                            outstanding;
  int                            fail_count;

  scalar_kalman_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  skf_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .run_over_i    (run_over),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always #2 clk_i = ~clk_i;

  // Result sink: short random stalls plus the odd long one that backs up a finished item.
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(999) < 2) begin
      sink_hold     <= $urandom_range(70, 45);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 27);
    end
  end

  // Called just after a falling edge; returns just after the falling edge past acceptance.
  task automatic send_sample(input logic [15:0] value);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 34)
      gap = ($urandom_range(99) < 8) ? $urandom_range(60, 4) : $urandom_range(3, 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Registers change only once every estimate has come out.
  task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skf_pkg::NOISE_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [skf_pkg::NOISE_W-1:0] pick_noise();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    if (roll < 60) return skf_pkg::NOISE_W'($urandom_range(16, 1));
    return skf_pkg::NOISE_W'($urandom_range(65535));
  endfunction

  initial begin
    int            sent;
    int            phase;
    int            count;
    int            level;
    int            value;
    int            which;
    int            drain;
    signal_style_e style;
    sent = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings, extremes and alternating bit patterns.
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    // No measurement noise: the gain is exactly one.
    write_reg(skf_pkg::REG_MEASUREMENT_NOISE, 16'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'd100);
    // No noise at all: the denominator is zero and the estimate holds.
    write_reg(skf_pkg::REG_PROCESS_NOISE, 16'd0);
    send_sample(16'hFFFB);
    send_sample(16'd1234);
    send_sample(16'h7FFF);
    // Largest noise: the prior covariance saturates.
    write_reg(skf_pkg::REG_PROCESS_NOISE, 16'hFFFF);
    write_reg(skf_pkg::REG_MEASUREMENT_NOISE, 16'hFFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    // Writes past the last register must leave the filter state alone.
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hFFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      which = $urandom_range(2);
      if (which != 1) write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
      if (which != 0) write_reg(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                  skf_pkg::NOISE_W'($urandom));
      calm  <= (phase == 2) || ($urandom_range(9) == 0);
      style = signal_style_e'($urandom_range(3));
      level = $urandom_range(65535) - 32768;
      count = $urandom_range(90, 30);
      for (int k = 0; k < count && sent < RANDOM_ITEMS; k++) begin
        case (style)
          SIG_NOISE: value = $urandom_range(65535) - 32768;
          SIG_LEVEL: value = level + int'($urandom_range(200)) - 100;
          SIG_SWING: value = (k % 2) ? 32767 : -32768;
          default:   value = level + k * 37;
        endcase
        if ($urandom_range(99) < 10) value = $urandom_range(65535) - 32768;
        if (value > 32767) value = 32767;
        if (value < -32768) value = -32768;
        send_sample(value[15:0]);
        sent++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;
    drain = 0;
    while (outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (60) @(negedge clk_i);
    run_over <= 1'b1;
    repeat (2) @(negedge clk_i);
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
